FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, ignored while reset is high
`define LWB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication
`define LWB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LWB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lwb_pkg.sv
// Shared constants, codes and types of the waveshaper / bitcrusher
package lwb_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int ENTRY_W     = 16;
   localparam int INDEX_W     = 10;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 12;
   localparam int POS_FRAC_W  = 16;
   localparam int DEPTH_SEL_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INPUT_GAIN  = 2'd0,
      CSR_OUTPUT_GAIN = 2'd1,
      CSR_INTERPOLATE = 2'd2,
      CSR_BIT_DEPTH   = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   localparam logic [DEPTH_SEL_W-1:0] DEPTH_SEL_8  = 2'd0;
   localparam logic [DEPTH_SEL_W-1:0] DEPTH_SEL_12 = 2'd1;
   localparam logic [DEPTH_SEL_W-1:0] DEPTH_SEL_16 = 2'd2;

   localparam logic [GAIN_W-1:0]      GAIN_UNITY        = 16'd4096;
   localparam logic                   INTERP_RESET      = 1'b1;
   localparam logic [DEPTH_SEL_W-1:0] DEPTH_SEL_RESET   = DEPTH_SEL_12;

   // Per-stage control: item present, and item is a table write
   typedef struct packed {
      logic vld;
      logic wr;
   } ctl_type;

endpackage

FILE: hw/rtl/lut_waveshaper_bitcrusher.sv
// Lookup-table waveshaper with bitcrusher, top level.
// Takes one item per clock while req_ready is high: a sample to shape or a
// transfer-table entry to store. A sample passes a pipeline of input gain,
// position, table read, interpolation, output gain, clamp, level and
// requantize steps. The table is a TABLE_DEPTH x 16 synchronous memory with
// two read ports, read at an entry and the next one, and a write port; writes
// pass through the same pipeline, so a sample sees every write accepted before
// it and none after. Entries are undefined until written; a write to an index
// at or beyond TABLE_DEPTH is dropped. Results wait in a sixteen-entry queue,
// and req_ready stays high while fewer than sixteen accepted samples still owe
// a result, so the block keeps taking items while the response side stalls for
// up to sixteen results. Configuration writes take effect at once and belong
// in idle periods.
`include "assert_macros.svh"

module lut_waveshaper_bitcrusher #(
   parameter int TABLE_DEPTH = lwb_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS = lwb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic [lwb_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [lwb_pkg::ENTRY_W-1:0]  req_entry_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,

   input  logic                                csr_wr_en,
   input  logic [lwb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lwb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(lwb_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CREDIT_MAX = CNT_W'(lwb_pkg::QUEUE_DEPTH);

   logic [lwb_pkg::GAIN_W-1:0]       input_gain_ff;
   logic [lwb_pkg::GAIN_W-1:0]       output_gain_ff;
   logic                             interpolate_ff;
   logic [lwb_pkg::DEPTH_SEL_W-1:0]  bit_depth_ff;

   logic [CNT_W-1:0]                 outstanding_ff, outstanding_in;

   logic                             req_xfer, rsp_xfer, is_write, sample_xfer;
   lwb_pkg::ctl_type                 in_ctl;
   lwb_pkg::ctl_type                 mem_ctl;
   logic [ADDR_W-1:0]                mem_idx;
   logic [lwb_pkg::POS_FRAC_W-1:0]   mem_frac;
   logic                             rd_vld;
   logic signed [lwb_pkg::ENTRY_W-1:0] rd_lo, rd_hi;
   logic [lwb_pkg::POS_FRAC_W-1:0]   rd_frac;
   logic                             push_vld;
   logic signed [SAMPLE_BITS-1:0]    push_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         input_gain_ff  <= lwb_pkg::GAIN_UNITY;
         output_gain_ff <= lwb_pkg::GAIN_UNITY;
         interpolate_ff <= lwb_pkg::INTERP_RESET;
         bit_depth_ff   <= lwb_pkg::DEPTH_SEL_RESET;
      end else if (csr_wr_en) begin
         case (lwb_pkg::csr_index_type'(csr_index))
            lwb_pkg::CSR_INPUT_GAIN:  input_gain_ff  <= csr_wdata;
            lwb_pkg::CSR_OUTPUT_GAIN: output_gain_ff <= csr_wdata;
            lwb_pkg::CSR_INTERPOLATE: interpolate_ff <= csr_wdata[0];
            lwb_pkg::CSR_BIT_DEPTH:   bit_depth_ff   <= csr_wdata[lwb_pkg::DEPTH_SEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // credit for every sample still owing a result; the queue holds them all
   assign req_ready   = (outstanding_ff < CREDIT_MAX);
   assign req_xfer    = req_valid && req_ready;
   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign is_write    = (lwb_pkg::op_type'(req_op) == lwb_pkg::OP_WRITE);
   assign sample_xfer = req_xfer && !is_write;

   always_comb begin
      case ({sample_xfer, rsp_xfer})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // drop writes beyond the table
   assign in_ctl.vld = req_xfer && (!is_write || int'(req_entry_index) < TABLE_DEPTH);
   assign in_ctl.wr  = is_write;

   lwb_addr_gen #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_addr_gen (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (in_ctl),
      .in_sample  (req_sample_in),
      .in_index   (req_entry_index),
      .in_value   (req_entry_value),
      .input_gain (input_gain_ff),
      .out_ctl    (mem_ctl),
      .out_idx    (mem_idx),
      .out_frac   (mem_frac)
   );

   lwb_table_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table_mem (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (mem_ctl),
      .in_idx   (mem_idx),
      .in_frac  (mem_frac),
      .out_vld  (rd_vld),
      .out_lo   (rd_lo),
      .out_hi   (rd_hi),
      .out_frac (rd_frac)
   );

   lwb_requant #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_requant (
      .clock         (clock),
      .reset         (reset),
      .in_vld        (rd_vld),
      .in_lo         (rd_lo),
      .in_hi         (rd_hi),
      .in_frac       (rd_frac),
      .interpolate   (interpolate_ff),
      .output_gain   (output_gain_ff),
      .bit_depth_sel (bit_depth_ff),
      .out_vld       (push_vld),
      .out_sample    (push_data)
   );

   lwb_out_queue #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_sample_out)
   );

   `LWB_ASSERT(a_credit_bound, outstanding_ff <= CREDIT_MAX, "outstanding count above queue depth")
   `LWB_ASSERT_IMPL(a_rsp_has_credit, rsp_valid, outstanding_ff != '0, "result without credit")
   `LWB_ASSERT_IMPL(a_push_has_credit, push_vld, outstanding_ff != '0, "push without credit")
   `LWB_ASSERT_NEXT(a_write_no_credit, req_xfer && is_write && !rsp_xfer, $stable(outstanding_ff), "table write took a credit")

endmodule

FILE: hw/rtl/lwb_addr_gen.sv
// Input gain, saturation and table position: three pipeline stages
module lwb_addr_gen #(
   parameter int TABLE_DEPTH = lwb_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS = lwb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lwb_pkg::ctl_type                  in_ctl,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample,
   input  logic [lwb_pkg::INDEX_W-1:0]       in_index,
   input  logic [lwb_pkg::ENTRY_W-1:0]       in_value,
   input  logic [lwb_pkg::GAIN_W-1:0]        input_gain,
   output lwb_pkg::ctl_type                  out_ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0]    out_idx,
   output logic [lwb_pkg::POS_FRAC_W-1:0]    out_frac
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int F      = SAMPLE_BITS - 1;
   localparam int PW     = SAMPLE_BITS + lwb_pkg::GAIN_W + 1;
   localparam int XW     = PW - lwb_pkg::GAIN_FRAC;
   localparam int UW     = F + 2;
   localparam int MW     = UW + ADDR_W;
   localparam int SHIFT  = F + 1 - lwb_pkg::POS_FRAC_W;

   localparam logic signed [PW-1:0] ROUND_HALF = PW'(2 ** (lwb_pkg::GAIN_FRAC - 1));
   localparam logic signed [XW-1:0] POS_ONE    = XW'(2 ** F);
   localparam logic signed [XW-1:0] NEG_ONE    = -POS_ONE;
   localparam logic [UW-1:0]        U_FULL     = UW'(2 ** (F + 1));
   localparam logic [MW-1:0]        DEPTH_M1   = MW'(TABLE_DEPTH - 1);

   // stage 1: gain product
   lwb_pkg::ctl_type                ctl1_ff;
   logic signed [PW-1:0]            prod_ff, prod_in;
   logic [ADDR_W-1:0]               waddr1_ff;
   logic [lwb_pkg::ENTRY_W-1:0]     wdata1_ff;

   // stage 2: offset sample in [0, 2]
   lwb_pkg::ctl_type                ctl2_ff;
   logic [UW-1:0]                   u_ff, u_in;
   logic [ADDR_W-1:0]               waddr2_ff;
   logic [lwb_pkg::ENTRY_W-1:0]     wdata2_ff;
   logic signed [PW-1:0]            rnd;
   logic signed [XW-1:0]            xr;

   // stage 3: table index and fraction
   lwb_pkg::ctl_type                ctl3_ff;
   logic [ADDR_W-1:0]               idx_ff, idx_in;
   logic [lwb_pkg::POS_FRAC_W-1:0]  frac_ff, frac_in;
   logic [MW-1:0]                   pos, pos_sh;

   assign prod_in = PW'(in_sample) * PW'($signed({1'b0, input_gain}));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
      end
      prod_ff   <= prod_in;
      waddr1_ff <= ADDR_W'(in_index);
      wdata1_ff <= in_value;
   end

   always_comb begin
      rnd = prod_ff + ROUND_HALF;
      xr  = rnd[PW-1:lwb_pkg::GAIN_FRAC];
      if (xr > POS_ONE) begin
         u_in = U_FULL;
      end else if (xr < NEG_ONE) begin
         u_in = '0;
      end else begin
         u_in = UW'(xr + POS_ONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
      u_ff      <= u_in;
      waddr2_ff <= waddr1_ff;
      wdata2_ff <= wdata1_ff;
   end

   // A write reuses the index and fraction fields for its address and data
   always_comb begin
      pos    = MW'(u_ff) * DEPTH_M1;
      pos_sh = pos >> SHIFT;
      if (ctl2_ff.wr) begin
         idx_in  = waddr2_ff;
         frac_in = wdata2_ff;
      end else begin
         idx_in  = pos_sh[lwb_pkg::POS_FRAC_W +: ADDR_W];
         frac_in = pos_sh[lwb_pkg::POS_FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl2_ff;
      end
      idx_ff  <= idx_in;
      frac_ff <= frac_in;
   end

   assign out_ctl  = ctl3_ff;
   assign out_idx  = idx_ff;
   assign out_frac = frac_ff;

endmodule

FILE: hw/rtl/lwb_table_mem.sv
// Transfer table: one write port, two registered read ports (entry and its neighbor)
module lwb_table_mem #(
   parameter int TABLE_DEPTH = lwb_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lwb_pkg::ctl_type                    in_ctl,
   input  logic [$clog2(TABLE_DEPTH)-1:0]      in_idx,
   input  logic [lwb_pkg::POS_FRAC_W-1:0]      in_frac,
   output logic                                out_vld,
   output logic signed [lwb_pkg::ENTRY_W-1:0]  out_lo,
   output logic signed [lwb_pkg::ENTRY_W-1:0]  out_hi,
   output logic [lwb_pkg::POS_FRAC_W-1:0]      out_frac
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);

   logic [lwb_pkg::ENTRY_W-1:0]     entries_ff [TABLE_DEPTH];
   logic [lwb_pkg::ENTRY_W-1:0]     lo_ff, hi_ff;
   logic [lwb_pkg::POS_FRAC_W-1:0]  frac_ff;
   logic                            vld_ff, vld_in;
   logic [ADDR_W-1:0]               hi_idx;
   logic                            wr_en;

   // Items reach this stage in order, so a write lands before any later read
   assign wr_en  = in_ctl.vld && in_ctl.wr;
   assign vld_in = in_ctl.vld && !in_ctl.wr;
   assign hi_idx = (in_idx == LAST_IDX) ? in_idx : in_idx + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[in_idx] <= in_frac;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= entries_ff[in_idx];
      hi_ff   <= entries_ff[hi_idx];
      frac_ff <= in_frac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_lo   = $signed(lo_ff);
   assign out_hi   = $signed(hi_ff);
   assign out_frac = frac_ff;

endmodule

FILE: hw/rtl/lwb_requant.sv
// Interpolation, output gain, saturation and bit-depth requantization: five stages
module lwb_requant #(
   parameter int SAMPLE_BITS = lwb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_vld,
   input  logic signed [lwb_pkg::ENTRY_W-1:0]  in_lo,
   input  logic signed [lwb_pkg::ENTRY_W-1:0]  in_hi,
   input  logic [lwb_pkg::POS_FRAC_W-1:0]      in_frac,
   input  logic                                interpolate,
   input  logic [lwb_pkg::GAIN_W-1:0]          output_gain,
   input  logic [lwb_pkg::DEPTH_SEL_W-1:0]     bit_depth_sel,
   output logic                                out_vld,
   output logic signed [SAMPLE_BITS-1:0]       out_sample
);

   localparam int W  = SAMPLE_BITS;
   localparam int F  = SAMPLE_BITS - 1;
   localparam int EW = lwb_pkg::ENTRY_W;
   localparam int DW = EW + 1;
   localparam int AW = 2 * DW;
   localparam int ZW = EW + lwb_pkg::GAIN_W + 1;
   localparam int NW = 29;
   localparam int TW = NW + 16;
   localparam int KW = 16;

   localparam logic signed [AW-1:0] ACC_HALF = AW'(2 ** 15);
   localparam logic signed [ZW-1:0] Z_MAX    = ZW'(2 ** 27);
   localparam logic signed [ZW-1:0] Z_MIN    = -Z_MAX;
   localparam logic [NW-1:0]        N_FULL   = NW'(2 ** 28);
   localparam logic [TW-1:0]        K_HALF   = TW'(2 ** 27);
   localparam logic [W-1:0]         OUT_MAX  = {1'b0, {F{1'b1}}};

   logic [4:0]               vld_ff;

   logic signed [DW-1:0]     diff;
   logic signed [AW-1:0]     dprod_ff, dprod_in;
   logic signed [EW-1:0]     lo_ff;

   logic signed [AW-1:0]     acc;
   logic signed [EW-1:0]     y_ff, y_in;

   logic signed [ZW-1:0]     z_ff, z_in;
   logic [NW-1:0]            n_ff, n_in;

   logic [4:0]               shamt;
   logic [TW-1:0]            t;
   logic [KW-1:0]            k_ff, k_in;

   logic [3:0]               p8, p12, p16;
   logic [W:0]               r8, r12, r16, r;
   logic [W:0]               q;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_vld};
      end
   end

   // interpolation product
   assign diff     = {in_hi[EW-1], in_hi} - {in_lo[EW-1], in_lo};
   assign dprod_in = AW'(diff) * AW'($signed({1'b0, in_frac}));

   always_ff @(posedge clock) begin
      dprod_ff <= dprod_in;
      lo_ff    <= in_lo;
   end

   // round half up and drop the 16 fraction bits
   always_comb begin
      acc  = $signed({{2{lo_ff[EW-1]}}, lo_ff, 16'b0}) + dprod_ff + ACC_HALF;
      y_in = interpolate ? acc[31:16] : lo_ff;
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign z_in = ZW'(y_ff) * ZW'($signed({1'b0, output_gain}));

   always_ff @(posedge clock) begin
      z_ff <= z_in;
   end

   // clamp to [-1, 1] and offset to unsigned [0, 2] with 27 fraction bits
   always_comb begin
      if (z_ff > Z_MAX) begin
         n_in = N_FULL;
      end else if (z_ff < Z_MIN) begin
         n_in = '0;
      end else begin
         n_in = NW'(z_ff + Z_MAX);
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
   end

   // level k = round(n * (2^b - 1) / 2^28), the product as shift and subtract
   always_comb begin
      case (bit_depth_sel)
         lwb_pkg::DEPTH_SEL_8:  shamt = 5'd8;
         lwb_pkg::DEPTH_SEL_16: shamt = 5'd16;
         default:               shamt = 5'd12;
      endcase
      t    = ({16'b0, n_ff} << shamt) - TW'(n_ff) + K_HALF;
      k_in = t[28 +: KW];
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   // k * 2^W / (2^b - 1) is k repeated as a binary fraction; keep W bits plus one
   // bit for rounding. The all-ones level rounds up to exactly 2^W.
   always_comb begin
      p8  = 4'd7;
      p12 = 4'd11;
      p16 = 4'd15;
      for (int j = W; j >= 0; j--) begin
         r8[j]  = k_ff[p8];
         r12[j] = k_ff[p12];
         r16[j] = k_ff[p16];
         p8     = (p8 == 4'd0)  ? 4'd7  : p8 - 4'd1;
         p12    = (p12 == 4'd0) ? 4'd11 : p12 - 4'd1;
         p16    = (p16 == 4'd0) ? 4'd15 : p16 - 4'd1;
      end
      case (bit_depth_sel)
         lwb_pkg::DEPTH_SEL_8:  r = r8;
         lwb_pkg::DEPTH_SEL_16: r = r16;
         default:               r = r12;
      endcase
      q = {1'b0, r[W:1]} + (W+1)'(r[0]);
   end

   assign out_vld    = vld_ff[4];
   assign out_sample = q[W] ? $signed(OUT_MAX) : $signed({~q[F], q[F-1:0]});

endmodule

FILE: hw/rtl/lwb_out_queue.sv
// Result queue between the pipeline and the response channel
module lwb_out_queue #(
   parameter int SAMPLE_BITS = lwb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_vld,
   input  logic signed [SAMPLE_BITS-1:0] push_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] out_data
);

   localparam int PTR_W = $clog2(lwb_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lwb_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(lwb_pkg::QUEUE_DEPTH - 1);

   logic [SAMPLE_BITS-1:0]  slots_ff [lwb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = $signed(slots_ff[rd_ptr_ff]);
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_vld) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_vld, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_vld) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: tb/lut_waveshaper_bitcrusher_test.sv
// Self-checking testbench for the lookup-table waveshaper / bitcrusher
module lut_waveshaper_bitcrusher_test;
   import lwb_pkg::*;

   localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
   localparam int DEPTH         = TABLE_DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 300;
   localparam int PHASE_COUNT   = 8;
   localparam int IDLE_PERCENT  = 32;
   localparam int STALL_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_PRINTED   = 100;
   localparam longint Z_LIMIT   = 64'sd134217728;   // 2^27, full scale of the Q.27 product

   // select value 3 has no name in the package; the block treats it as twelve bits
   localparam logic [DEPTH_SEL_W-1:0] DEPTH_SEL_SPARE = 2'd3;

   typedef enum int {
      FILL_RANDOM,
      FILL_RAMP
   } fill_kind_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   class shaper_scoreboard;
      logic signed [ENTRY_W-1:0] entries [DEPTH];
      logic [GAIN_W-1:0]         in_gain;
      logic [GAIN_W-1:0]         out_gain;
      logic                      interp;
      logic [DEPTH_SEL_W-1:0]    depth_sel;
      sample_type                expected_samples [$];
      int                        error_count;
      int                        samples_checked;
      int                        writes_noted;

      function new();
         foreach (entries[i]) entries[i] = '0;
         in_gain         = GAIN_UNITY;
         out_gain        = GAIN_UNITY;
         interp          = INTERP_RESET;
         depth_sel       = DEPTH_SEL_RESET;
         error_count     = 0;
         samples_checked = 0;
         writes_noted    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_INPUT_GAIN:  in_gain = val[GAIN_W-1:0];
            CSR_OUTPUT_GAIN: out_gain = val[GAIN_W-1:0];
            CSR_INTERPOLATE: interp = val[0];
            CSR_BIT_DEPTH:   depth_sel = val[DEPTH_SEL_W-1:0];
            default: ;
         endcase
      endfunction

      function sample_type shape_sample(sample_type s);
         longint x, y, yh, acc, z, n, steps, k, res, pos, idx, hi, frac;
         int bits;
         x = longint'(s) * longint'(in_gain);
         x = (x + 2048) >>> GAIN_FRAC;
         if (x < -32768) x = -32768;
         if (x > 32768) x = 32768;
         pos  = (x + 32768) * (DEPTH - 1);
         idx  = pos >>> POS_FRAC_W;
         frac = pos & 65535;
         if (idx > DEPTH - 1) idx = DEPTH - 1;
         hi = (idx + 1 > DEPTH - 1) ? DEPTH - 1 : idx + 1;
         y = longint'(entries[idx]);
         if (interp) begin
            yh  = longint'(entries[hi]);
            acc = y * 65536 + (yh - y) * frac;
            y   = (acc + 32768) >>> POS_FRAC_W;
         end
         z = y * longint'(out_gain);
         if (z < -Z_LIMIT) z = -Z_LIMIT;
         if (z > Z_LIMIT) z = Z_LIMIT;
         n = z + Z_LIMIT;
         case (depth_sel)
            DEPTH_SEL_8:  bits = 8;
            DEPTH_SEL_16: bits = 16;
            default:      bits = 12;
         endcase
         steps = (longint'(1) <<< bits) - 1;
         k     = (n * steps + Z_LIMIT) >>> 28;
         res   = ((k <<< (SAMPLE_W + 1)) + steps) / (2 * steps) - 32768;
         if (res > 32767) res = 32767;
         return res[SAMPLE_W-1:0];
      endfunction

      function void note_item(op_type op, sample_type s, logic [INDEX_W-1:0] idx,
                              logic signed [ENTRY_W-1:0] val);
         if (op == OP_WRITE) begin
            if (idx < DEPTH) entries[idx] = val;
            writes_noted++;
         end else begin
            expected_samples = {expected_samples, shape_sample(s)};
         end
      endfunction

      task report_mismatch(string msg);
         error_count++;
         if (error_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
      endtask

      task check_sample(sample_type got);
         sample_type want;
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding", got));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (got !== want)
               report_mismatch($sformatf("sample_out got %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_op = OP_SAMPLE;
   sample_type                  req_sample_in = '0;
   logic [INDEX_W-1:0]          req_entry_index = '0;
   logic signed [ENTRY_W-1:0]   req_entry_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   sample_type                  rsp_sample_out;
   logic                        csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   shaper_scoreboard sb;
   bit no_idle = 1'b0;
   int rsp_hold_cycles = 0;
   int setting_count = 0;
   int cycle_count = 0;

   lut_waveshaper_bitcrusher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sample_in   (req_sample_in),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
   end

   // response side: check each transfer, then pick ready for the next cycle
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_sample(rsp_sample_out);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic sample_type pick_sample();
      case ($urandom_range(7))
         0:       return sample_type'(-32768);
         1:       return sample_type'(32767);
         2:       return sample_type'(int'($urandom_range(64)) - 32);
         3:       return sample_type'(32767 - int'($urandom_range(255)));
         4:       return sample_type'(-32768 + int'($urandom_range(255)));
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic send_item(op_type op, sample_type s, logic [INDEX_W-1:0] idx,
                            logic signed [ENTRY_W-1:0] val);
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_sample_in   <= s;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(op, s, idx, val);
   endtask

   // unused fields carry noise so every bit toggles
   task automatic send_sample(sample_type s);
      send_item(OP_SAMPLE, s, INDEX_W'($urandom()), ENTRY_W'($urandom()));
   endtask

   task automatic send_write(logic [INDEX_W-1:0] idx, logic signed [ENTRY_W-1:0] val);
      send_item(OP_WRITE, sample_type'($urandom()), idx, val);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      release_req();
      while (sb.expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic load_table(fill_kind_type kind);
      logic signed [ENTRY_W-1:0] val;
      for (int i = 0; i < DEPTH; i++) begin
         if (kind == FILL_RAMP) val = ENTRY_W'(i * 64 - 32768);
         else val = ENTRY_W'($urandom());
         if (i == 0) val = -32768;
         if (i == DEPTH - 1) val = 32767;
         send_write(INDEX_W'(i), val);
      end
   endtask

   // registers change only with the pipeline empty; writes owe no result, so settle too
   task automatic apply_settings(logic [GAIN_W-1:0] ig, logic [GAIN_W-1:0] og, logic ip,
                                 logic [DEPTH_SEL_W-1:0] ds);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_INPUT_GAIN;
      csr_wdata <= ig;
      @(posedge clock);
      csr_index <= CSR_OUTPUT_GAIN;
      csr_wdata <= og;
      @(posedge clock);
      csr_index <= CSR_INTERPOLATE;
      csr_wdata <= CSR_DATA_W'(ip);
      @(posedge clock);
      csr_index <= CSR_BIT_DEPTH;
      csr_wdata <= CSR_DATA_W'(ds);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(CSR_INPUT_GAIN, ig);
      sb.write_reg(CSR_OUTPUT_GAIN, og);
      sb.write_reg(CSR_INTERPOLATE, CSR_DATA_W'(ip));
      sb.write_reg(CSR_BIT_DEPTH, CSR_DATA_W'(ds));
      setting_count++;
   endtask

   initial begin
      int per_phase;
      int drain_wait;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every entry is written before the first sample reads the table
      load_table(FILL_RANDOM);

      // reset settings: unity gains, interpolation, twelve bits
      send_sample(-32768);
      send_sample(32767);
      send_sample(0);
      send_sample(-1);
      send_sample(1);
      send_sample(16384);
      send_sample(-16384);
      // top of the table: these samples read the last entry as the upper neighbor
      send_write(DEPTH - 2, -32768);
      send_write(DEPTH / 2 - 1, 32767);
      send_sample(32766);
      send_sample(32767);

      // full-scale gains saturate both ends; the positive end clips below 1.0
      apply_settings(16'hFFFF, 16'hFFFF, 1'b0, DEPTH_SEL_8);
      send_sample(32767);
      send_sample(-32768);
      send_sample(3);
      send_sample(-3);
      apply_settings(16'h0000, 16'h0000, 1'b1, DEPTH_SEL_16);
      send_sample(32767);
      send_sample(-32768);
      apply_settings(GAIN_UNITY, GAIN_UNITY, 1'b1, DEPTH_SEL_SPARE);
      send_sample(12345);
      send_sample(-12345);
      send_sample(32767);
      apply_settings(16'd8191, GAIN_UNITY, 1'b0, DEPTH_SEL_12);
      send_sample(8191);
      send_sample(-8191);

      per_phase = RANDOM_ITEMS / PHASE_COUNT;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: apply_settings(GAIN_UNITY, GAIN_UNITY, 1'b1, DEPTH_SEL_16);
            1: apply_settings(16'hFFFF, GAIN_UNITY, 1'b1, DEPTH_SEL_8);
            2: apply_settings(16'h0000, 16'hFFFF, 1'b0, DEPTH_SEL_12);
            3: apply_settings(GAIN_W'($urandom_range(16383)), GAIN_W'($urandom_range(16383)),
                              1'b1, DEPTH_SEL_SPARE);
            4: apply_settings(GAIN_UNITY, 16'hFFFF, 1'b0, DEPTH_SEL_16);
            6: apply_settings(16'd2048, 16'd8192, 1'b1, DEPTH_SEL_8);
            default: apply_settings(GAIN_W'($urandom()), GAIN_W'($urandom()),
                                    1'($urandom()), DEPTH_SEL_W'($urandom()));
         endcase
         no_idle = (p == 4 || p == 5);
         // hold the response side off so the result queue fills and input stalls
         if (p == 3) rsp_hold_cycles = STALL_CYCLES;
         for (int i = 0; i < per_phase; i++) begin
            if (p == 5 && i == per_phase / 2) drain_results();
            if ($urandom_range(99) < 80) send_sample(pick_sample());
            else send_write(INDEX_W'($urandom()), ENTRY_W'($urandom()));
         end
      end
      no_idle = 1'b0;

      release_req();
      drain_wait = 0;
      while (sb.expected_samples.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_samples.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived",
                                      sb.expected_samples.size()));

      $display("Checked %0d shaped samples alongside %0d table writes under %0d settings",
               sb.samples_checked, sb.writes_noted, setting_count);
      $display("Exercised all bit depths, both read modes, gain extremes, a long stall");
      if (sb.error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", sb.error_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
